[hdl/istft_pkg.sv]
// Shared types, sizes and constant tables of the inverse STFT overlap-add block.
// Twiddle and window tables are generated at elaboration by a rotation routine.
// No dependencies.
package istft_pkg;

  localparam int FFT_SIZE    = 16;
  localparam int HOP_SIZE    = 4;
  localparam int BIN_COUNT   = 9;
  localparam int FFT_W       = $clog2(FFT_SIZE);
  localparam int BIN_W       = $clog2(BIN_COUNT);
  localparam int LIM_MAX     = (HOP_SIZE > FFT_SIZE / 2) ? HOP_SIZE : FFT_SIZE / 2;
  localparam int J_W         = (LIM_MAX > 1) ? $clog2(LIM_MAX) : 1;

  localparam longint PI_Q16          = 205887;
  localparam longint TWO_PI_Q16      = 411775;
  localparam longint HALF_PI_Q16     = 102944;
  localparam longint CORDIC_GAIN_Q30 = 652032874;
  localparam longint ONE_Q30         = 1073741824;
  localparam int     MAG_CLAMP       = 25600;
  localparam int     CORDIC_STEPS    = 16;
  localparam int     STEP_W          = $clog2(CORDIC_STEPS);

  localparam int ANG_W     = 21;
  localparam int MAG_W     = 15;
  localparam int ROT_W     = 33;
  localparam int FRONT_P_W = 49;
  localparam int SPEC_W    = 24;
  localparam int TW_W      = 32;
  localparam int PROD_W    = 56;
  localparam int ACC_W     = 64;
  localparam int V_W       = 32;
  localparam int WIN_W     = 15;
  localparam int VW_W      = 48;
  localparam int OV_W      = 32;
  localparam int ENV_W     = 24;
  localparam int ENV_INC_W = 20;
  localparam int FRAME_W   = 16;
  localparam int SAMPLE_W  = 18;
  localparam int DIV_NUM_W = 48;
  localparam int DIV_CW    = $clog2(DIV_NUM_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [15:0]        magnitude;
    logic signed [15:0] phase;
    logic               final_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_run;
    logic                       stream_done;
  } out_item_t;

  typedef struct packed {
    logic signed [SPEC_W-1:0] re;
    logic signed [SPEC_W-1:0] im;
    logic                     fin;
  } bin_t;

  typedef logic [FFT_SIZE-1:0][TW_W-1:0]      tw_tab_t;
  typedef logic [FFT_SIZE-1:0][WIN_W-1:0]     win_tab_t;
  typedef logic [FFT_SIZE-1:0][ENV_INC_W-1:0] env_tab_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    case (i)
      4'd0:    return 21'sd51472;
      4'd1:    return 21'sd30386;
      4'd2:    return 21'sd16055;
      4'd3:    return 21'sd8150;
      4'd4:    return 21'sd4091;
      4'd5:    return 21'sd2047;
      4'd6:    return 21'sd1024;
      4'd7:    return 21'sd512;
      4'd8:    return 21'sd256;
      4'd9:    return 21'sd128;
      4'd10:   return 21'sd64;
      4'd11:   return 21'sd32;
      4'd12:   return 21'sd16;
      4'd13:   return 21'sd8;
      4'd14:   return 21'sd4;
      default: return 21'sd2;
    endcase
  endfunction

  function automatic logic signed [63:0] round_shr(input logic signed [63:0] x, input int s);
    logic [63:0] m;
    logic [63:0] r;
    m = x[63] ? 64'(-x) : 64'(x);
    r = (m + (64'd1 << (s - 1))) >> s;
    return x[63] ? $signed(-r) : $signed(r);
  endfunction

  function automatic longint cordic_ref(input longint ang, input bit want_sin);
    longint r;
    longint x;
    longint y;
    longint nx;
    bit     neg;
    r   = ang % TWO_PI_Q16;
    x   = CORDIC_GAIN_Q30;
    y   = 0;
    neg = 1'b0;
    if (r > PI_Q16) r = r - TWO_PI_Q16;
    if (r < -PI_Q16) r = r + TWO_PI_Q16;
    if (r > HALF_PI_Q16) begin
      r   = r - PI_Q16;
      neg = 1'b1;
    end else if (r < -HALF_PI_Q16) begin
      r   = r + PI_Q16;
      neg = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        r  = r - longint'(atan_q16(STEP_W'(i)));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        r  = r + longint'(atan_q16(STEP_W'(i)));
      end
      x = nx;
    end
    if (want_sin) return neg ? -y : y;
    return neg ? -x : x;
  endfunction

  function automatic longint twiddle_angle(input int m);
    return (longint'(m) * TWO_PI_Q16 * 2 + FFT_SIZE) / (2 * FFT_SIZE);
  endfunction

  function automatic tw_tab_t make_twiddles(input bit want_sin);
    tw_tab_t t;
    for (int m = 0; m < FFT_SIZE; m++) begin
      t[m] = TW_W'(cordic_ref(twiddle_angle(m), want_sin));
    end
    return t;
  endfunction

  function automatic longint hann_value(input int m);
    longint d;
    longint w;
    d = ONE_Q30 - cordic_ref(twiddle_angle(m), 1'b0);
    w = (d >= 0) ? (d + 65536) / 131072 : -((-d + 65536) / 131072);
    if (w < 0) w = 0;
    if (w > 16384) w = 16384;
    return w;
  endfunction

  function automatic win_tab_t make_hann();
    win_tab_t t;
    for (int m = 0; m < FFT_SIZE; m++) t[m] = WIN_W'(hann_value(m));
    return t;
  endfunction

  function automatic env_tab_t make_env_inc();
    env_tab_t t;
    longint   w;
    for (int m = 0; m < FFT_SIZE; m++) begin
      w    = hann_value(m);
      t[m] = ENV_INC_W'((w * w + 256) >>> 9);
    end
    return t;
  endfunction

  localparam tw_tab_t  TW_COS  = make_twiddles(1'b0);
  localparam tw_tab_t  TW_SIN  = make_twiddles(1'b1);
  localparam win_tab_t HANN    = make_hann();
  localparam env_tab_t ENV_INC = make_env_inc();

endpackage

[hdl/istft_overlap_add.sv]
// Top level of the streaming inverse STFT with Hann overlap-add.
// Instantiates istft_front, istft_fifo and istft_back; depends on istft_pkg.
//
// Bins enter one per beat, bin 0 first, nine per frame. The front end converts
// each bin with a 16-step rotation, one multiply and one handoff, and hands its
// result to a two-entry queue. On the last bin of a frame the back end runs a
// 16-point inverse DFT through one multiply-accumulate pair, and then a
// bit-serial divider for each emitted sample: four per frame, eight on the
// final frame, none for the first frames that fall in the trimmed head.
// While the back end is busy the front end keeps converting the next frame's
// bins until the queue is full. The output register lets a sample wait for
// the consumer while the next one is being computed.
module istft_overlap_add (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  istft_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output istft_pkg::out_item_t out_data_o
);
  import istft_pkg::*;

  logic q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  bin_t q_wr_data, q_rd_data;

  istft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .bin_valid_o(q_wr_valid),
    .bin_ready_i(q_wr_ready),
    .bin_o      (q_wr_data)
  );

  istft_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(q_wr_valid),
    .wr_ready_o(q_wr_ready),
    .wr_data_i (q_wr_data),
    .rd_valid_o(q_rd_valid),
    .rd_ready_i(q_rd_ready),
    .rd_data_o (q_rd_data)
  );

  istft_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bin_valid_i(q_rd_valid),
    .bin_ready_o(q_rd_ready),
    .bin_i      (q_rd_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

[hdl/istft_front.sv]
// Front end: accepts one spectrum bin per beat and turns magnitude and phase
// into a rounded real/imaginary pair with an iterative 16-step rotation.
// Depends on istft_pkg.
module istft_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  istft_pkg::in_item_t in_data_i,
  output logic               bin_valid_o,
  input  logic               bin_ready_i,
  output istft_pkg::bin_t    bin_o
);
  import istft_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_ROT  = 4'b0010,
    F_MUL  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_e;

  localparam logic signed [ANG_W-1:0] K_PI   = ANG_W'(PI_Q16);
  localparam logic signed [ANG_W-1:0] K_2PI  = ANG_W'(TWO_PI_Q16);
  localparam logic signed [ANG_W-1:0] K_HPI  = ANG_W'(HALF_PI_Q16);
  localparam logic signed [ROT_W-1:0] K_GAIN = ROT_W'(CORDIC_GAIN_Q30);

  front_state_e state_q, state_d;
  logic [MAG_W-1:0]           mag_q;
  logic                       fin_q;
  logic                       neg_q;
  logic signed [ANG_W-1:0]    ang_q;
  logic signed [ROT_W-1:0]    x_q, y_q;
  logic [STEP_W-1:0]          step_q;
  logic signed [FRONT_P_W-1:0] pr_q, pi_q;

  logic signed [ANG_W-1:0] ang, a0, a1, a2, at;
  logic                    neg;
  logic [MAG_W-1:0]        mag_c;
  logic signed [ROT_W-1:0] xs, ys, cv, sv;

  always_comb begin
    ang = ANG_W'($signed({in_data_i.phase, 4'b0000}));
    if (ang >= K_2PI) begin
      a0 = ang - K_2PI;
    end else if (ang <= -K_2PI) begin
      a0 = ang + K_2PI;
    end else begin
      a0 = ang;
    end
    if (a0 > K_PI) begin
      a1 = a0 - K_2PI;
    end else if (a0 < -K_PI) begin
      a1 = a0 + K_2PI;
    end else begin
      a1 = a0;
    end
    neg = 1'b0;
    a2  = a1;
    if (a1 > K_HPI) begin
      a2  = a1 - K_PI;
      neg = 1'b1;
    end else if (a1 < -K_HPI) begin
      a2  = a1 + K_PI;
      neg = 1'b1;
    end
    mag_c = (in_data_i.magnitude > 16'(MAG_CLAMP)) ? MAG_W'(MAG_CLAMP)
                                                    : in_data_i.magnitude[MAG_W-1:0];
  end

  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;
  assign at = atan_q16(step_q);
  assign cv = neg_q ? -x_q : x_q;
  assign sv = neg_q ? -y_q : y_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_ROT;
      F_ROT:   if (step_q == STEP_W'(CORDIC_STEPS - 1)) state_d = F_MUL;
      F_MUL:   state_d = F_PUSH;
      F_PUSH:  if (bin_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        mag_q  <= mag_c;
        fin_q  <= in_data_i.final_frame;
        neg_q  <= neg;
        ang_q  <= a2;
        x_q    <= K_GAIN;
        y_q    <= '0;
        step_q <= '0;
      end
      F_ROT: begin
        if (ang_q >= 0) begin
          x_q   <= x_q - ys;
          y_q   <= y_q + xs;
          ang_q <= ang_q - at;
        end else begin
          x_q   <= x_q + ys;
          y_q   <= y_q - xs;
          ang_q <= ang_q + at;
        end
        step_q <= step_q + 1'b1;
      end
      F_MUL: begin
        pr_q <= $signed({1'b0, mag_q}) * cv;
        pi_q <= $signed({1'b0, mag_q}) * sv;
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o  = (state_q == F_IDLE);
  assign bin_valid_o = (state_q == F_PUSH);
  assign bin_o.re    = SPEC_W'(round_shr(64'(pr_q), 22));
  assign bin_o.im    = SPEC_W'(round_shr(64'(pi_q), 22));
  assign bin_o.fin   = fin_q;

endmodule

[hdl/istft_fifo.sv]
// Short queue of converted bins between the front end and the back end.
// Depends on istft_pkg.
module istft_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  istft_pkg::bin_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output istft_pkg::bin_t rd_data_o
);
  import istft_pkg::*;

  bin_t                      mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] count_q;
  logic push, pop;

  assign wr_ready_o = (count_q != ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[hdl/istft_div.sv]
// Bit-serial divider for one output sample: rounded quotient of accumulator
// and envelope, saturated to the sample range. Depends on istft_pkg.
module istft_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [istft_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [istft_pkg::ENV_W-1:0]          den_i,
  output logic                                 busy_o,
  output logic signed [istft_pkg::SAMPLE_W-1:0] quo_o
);
  import istft_pkg::*;

  logic                  busy_q;
  logic [DIV_CW-1:0]     cnt_q;
  logic                  neg_q;
  logic [DIV_NUM_W-1:0]  dvd_q, quo_q, mag;
  logic [ENV_W-1:0]      den_q, rem_q;
  logic [ENV_W:0]        trial;
  logic                  fits;

  assign mag   = (num_i[DIV_NUM_W-1] ? DIV_NUM_W'(-num_i) : DIV_NUM_W'(num_i))
                 + DIV_NUM_W'(den_i >> 1);
  assign trial = {rem_q, dvd_q[DIV_NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_NUM_W - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DIV_NUM_W-1];
      dvd_q <= mag;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= fits ? ENV_W'(trial - {1'b0, den_q}) : ENV_W'(trial);
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
    end
  end

  always_comb begin
    if (!neg_q) begin
      quo_o = (quo_q > DIV_NUM_W'(131071)) ? SAMPLE_W'(131071) : $signed(quo_q[SAMPLE_W-1:0]);
    end else begin
      quo_o = (quo_q > DIV_NUM_W'(131072)) ? $signed(SAMPLE_W'(131072))
                                           : $signed(SAMPLE_W'(0) - quo_q[SAMPLE_W-1:0]);
    end
  end

  assign busy_o = busy_q;

endmodule

[hdl/istft_back.sv]
// Back end: collects bins of a frame, runs the inverse DFT with one shared
// multiply-accumulate pair, windows, overlap-adds and emits samples.
// Depends on istft_pkg and istft_div.
module istft_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 bin_valid_i,
  output logic                 bin_ready_o,
  input  istft_pkg::bin_t      bin_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output istft_pkg::out_item_t out_data_o
);
  import istft_pkg::*;

  typedef enum logic [9:0] {
    B_BIN   = 10'b0000000001,
    B_MAC   = 10'b0000000010,
    B_DRAIN = 10'b0000000100,
    B_RND   = 10'b0000001000,
    B_MULW  = 10'b0000010000,
    B_UPD   = 10'b0000100000,
    B_EMIT  = 10'b0001000000,
    B_DIV   = 10'b0010000000,
    B_OUT   = 10'b0100000000,
    B_END   = 10'b1000000000
  } back_state_e;

  back_state_e state_q;

  logic signed [SPEC_W-1:0] spec_re_q [BIN_COUNT];
  logic signed [SPEC_W-1:0] spec_im_q [BIN_COUNT];
  logic signed [OV_W-1:0]   ov_q [FFT_SIZE];
  logic [ENV_W-1:0]         env_q [FFT_SIZE];

  logic [BIN_W-1:0]         bin_idx_q;
  logic [FRAME_W-1:0]       frame_q;
  logic                     fin_q;
  logic [FFT_W-1:0]         n_q, k_q, tw_q;
  logic [J_W-1:0]           j_q;
  logic                     a_vld_q;
  logic signed [PROD_W-1:0] prr_q, pri_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [V_W-1:0]    v_q;
  logic signed [VW_W-1:0]   vw_q;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_q;

  logic [FFT_W-1:0]         src, rd_idx, tw_next;
  logic                     mirrored, in_range;
  logic signed [SPEC_W-1:0] xr, xi;
  logic signed [OV_W-1:0]   ov_rd;
  logic [ENV_W-1:0]         env_rd;
  logic signed [63:0]       ov_sum;
  logic signed [OV_W-1:0]   ov_new;
  logic [ENV_W:0]           env_sum;
  logic [23:0]              pos;
  logic                     skip, j_last, out_free;
  logic [J_W-1:0]           lim_m1;
  logic                     div_start, div_busy;
  logic signed [DIV_NUM_W-1:0] div_num;
  logic [ENV_W-1:0]         div_den;
  logic signed [SAMPLE_W-1:0] div_quo;

  always_comb begin
    mirrored = (k_q > FFT_W'(FFT_SIZE / 2));
    src      = mirrored ? FFT_W'(FFT_SIZE - int'(k_q)) : k_q;
    in_range = (int'(src) < BIN_COUNT);
    xr       = in_range ? spec_re_q[src[BIN_W-1:0]] : '0;
    xi       = in_range ? spec_im_q[src[BIN_W-1:0]] : '0;
    if (mirrored) xi = -xi;
    tw_next  = (int'(tw_q) + int'(n_q) >= FFT_SIZE) ? FFT_W'(int'(tw_q) + int'(n_q) - FFT_SIZE)
                                                    : FFT_W'(int'(tw_q) + int'(n_q));
  end

  assign rd_idx  = (state_q == B_UPD) ? n_q : FFT_W'(j_q);
  assign ov_rd   = ov_q[rd_idx];
  assign env_rd  = env_q[rd_idx];

  always_comb begin
    ov_sum = 64'(ov_rd) + round_shr(64'(vw_q), 14);
    if (ov_sum > 64'sh7FFF_FFFF) begin
      ov_new = OV_W'(32'h7FFF_FFFF);
    end else if (ov_sum < -64'sh8000_0000) begin
      ov_new = OV_W'(32'h8000_0000);
    end else begin
      ov_new = OV_W'(ov_sum);
    end
    env_sum = {1'b0, env_rd} + (ENV_W + 1)'(ENV_INC[n_q]);
  end

  assign pos       = 24'(frame_q) * 24'(HOP_SIZE) + 24'(j_q);
  assign skip      = (pos < 24'(FFT_SIZE / 2));
  assign lim_m1    = fin_q ? J_W'(FFT_SIZE / 2 - 1) : J_W'(HOP_SIZE - 1);
  assign j_last    = (j_q == lim_m1);
  assign out_free  = !out_valid_q || out_ready_i;
  assign div_start = (state_q == B_EMIT) && !skip;
  assign div_num   = $signed({{(DIV_NUM_W - OV_W - 15){ov_rd[OV_W-1]}}, ov_rd, 15'b0});
  assign div_den   = (env_rd == '0) ? ENV_W'(1) : env_rd;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (state_q == B_OUT && out_free) out_valid_d = 1'b1;
  end

  istft_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_BIN;
      bin_idx_q   <= '0;
      frame_q     <= '0;
      fin_q       <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
      tw_q        <= '0;
      j_q         <= '0;
      a_vld_q     <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < FFT_SIZE; i++) begin
        ov_q[i]  <= '0;
        env_q[i] <= '0;
      end
    end else begin
      a_vld_q <= (state_q == B_MAC);
      if (a_vld_q) acc_q <= acc_q + ACC_W'(prr_q) - ACC_W'(pri_q);
      out_valid_q <= out_valid_d;
      case (state_q)
        B_BIN: begin
          if (bin_valid_i) begin
            if (bin_idx_q == BIN_W'(BIN_COUNT - 1)) begin
              bin_idx_q <= '0;
              fin_q     <= bin_i.fin;
              n_q       <= '0;
              k_q       <= '0;
              tw_q      <= '0;
              state_q   <= B_MAC;
            end else begin
              bin_idx_q <= bin_idx_q + 1'b1;
            end
          end
        end
        B_MAC: begin
          k_q  <= k_q + 1'b1;
          tw_q <= tw_next;
          if (k_q == FFT_W'(FFT_SIZE - 1)) state_q <= B_DRAIN;
        end
        B_DRAIN: state_q <= B_RND;
        B_RND: begin
          acc_q   <= '0;
          state_q <= B_MULW;
        end
        B_MULW: state_q <= B_UPD;
        B_UPD: begin
          ov_q[n_q]  <= ov_new;
          env_q[n_q] <= env_sum[ENV_W] ? '1 : env_sum[ENV_W-1:0];
          k_q        <= '0;
          tw_q       <= '0;
          if (n_q == FFT_W'(FFT_SIZE - 1)) begin
            j_q     <= '0;
            state_q <= B_EMIT;
          end else begin
            n_q     <= n_q + 1'b1;
            state_q <= B_MAC;
          end
        end
        B_EMIT: begin
          if (!skip) begin
            state_q <= B_DIV;
          end else if (j_last) begin
            state_q <= B_END;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        B_DIV: if (!div_busy) state_q <= B_OUT;
        B_OUT: begin
          if (out_free) begin
            if (j_last) begin
              state_q <= B_END;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= B_EMIT;
            end
          end
        end
        B_END: begin
          if (fin_q) begin
            frame_q <= '0;
            for (int i = 0; i < FFT_SIZE; i++) begin
              ov_q[i]  <= '0;
              env_q[i] <= '0;
            end
          end else begin
            if (frame_q != '1) frame_q <= frame_q + 1'b1;
            for (int i = 0; i < FFT_SIZE; i++) begin
              if (i + HOP_SIZE < FFT_SIZE) begin
                ov_q[i]  <= ov_q[(i + HOP_SIZE) % FFT_SIZE];
                env_q[i] <= env_q[(i + HOP_SIZE) % FFT_SIZE];
              end else begin
                ov_q[i]  <= '0;
                env_q[i] <= '0;
              end
            end
          end
          state_q <= B_BIN;
        end
        default: state_q <= B_BIN;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_BIN && bin_valid_i) begin
      spec_re_q[bin_idx_q] <= bin_i.re;
      spec_im_q[bin_idx_q] <= bin_i.im;
    end
    if (state_q == B_MAC) begin
      prr_q <= xr * $signed(TW_COS[tw_q]);
      pri_q <= xi * $signed(TW_SIN[tw_q]);
    end
    if (state_q == B_RND) v_q <= V_W'(round_shr(acc_q, FFT_W + 28));
    if (state_q == B_MULW) vw_q <= v_q * $signed({1'b0, HANN[n_q]});
    if (state_q == B_OUT && out_free) begin
      out_q.sample      <= div_quo;
      out_q.last_of_run <= j_last;
      out_q.stream_done <= j_last && fin_q;
    end
  end

  assign bin_ready_o = (state_q == B_BIN);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
